### design/mpf_pkg.sv
// ----------------------------------------------------------------------------
// mpf_pkg: shared types and constants for the streaming 2D max-pool block
// Sample type, item tag carried down the line-store chain, register indexes
// and the signed maximum used by every cell.
// ----------------------------------------------------------------------------
package mpf_pkg;

    // sizing
    localparam int MAX_COLS     = 1024;
    localparam int MAX_KERNEL   = 8;
    localparam int SAMPLE_WIDTH = 16;

    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int SEL_W      = $clog2(MAX_KERNEL);
    localparam int LINE_CELLS = MAX_KERNEL - 1;
    localparam int DIM_W      = 11;
    localparam int POS_W      = 10;
    localparam int KER_W      = 4;

    localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(1024);
    localparam logic [DIM_W-1:0] COL_LIMIT =
        (MAX_COLS < 1024) ? DIM_W'(MAX_COLS) : DIM_W'(1024);
    localparam logic [KER_W-1:0] KER_LIMIT = KER_W'(MAX_KERNEL);

    // register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_CHANNELS    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IN_ROWS     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_IN_COLS     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROWS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_COLS = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE      = 3'd5;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    localparam sample_t MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // per-item control travelling alongside the data
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        logic             emit;
        logic             last;
    } mpf_tag_t;

    function automatic sample_t sample_max(input sample_t a, input sample_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

### design/mpf_line_cell.sv
// ----------------------------------------------------------------------------
// mpf_line_cell: one row of the line store
// Holds one earlier image row. For each item it writes the incoming row value
// at the item's column, hands the older row at that column to the next cell
// and folds the incoming value into the running column maximum when row_en is set.
// ----------------------------------------------------------------------------
module mpf_line_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              row_en,
    input  mpf_pkg::mpf_tag_t tag_in,
    input  mpf_pkg::sample_t  d_in,
    input  mpf_pkg::sample_t  pm_in,
    output mpf_pkg::mpf_tag_t tag_out,
    output mpf_pkg::sample_t  d_out,
    output mpf_pkg::sample_t  pm_out
);
    import mpf_pkg::*;

    sample_t  mem [0:MAX_COLS-1];
    mpf_tag_t tag_reg;
    sample_t  d_out_reg;
    sample_t  pm_out_reg;
    sample_t  pm_next;

    // fold this row in only when it lies inside the window height
    always_comb
    begin
        pm_next = row_en ? sample_max(pm_in, d_in) : pm_in;
    end

    // row memory: read-first, so the older row comes out as the new one lands
    always_ff @(posedge clk)
    begin
        if (advance && tag_in.valid)
        begin
            mem[tag_in.col] <= d_in;
            d_out_reg       <= mem[tag_in.col];
            pm_out_reg      <= pm_next;
        end
    end

    // item tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (advance)
        begin
            tag_reg <= tag_in;
        end
    end

    assign tag_out = tag_reg;
    assign d_out   = d_out_reg;
    assign pm_out  = pm_out_reg;

endmodule

### design/mpf_win_cell.sv
// ----------------------------------------------------------------------------
// mpf_win_cell: one step of the horizontal window
// Keeps the maximum of the latest column maxima over a span one longer than
// its left neighbour's, so cell k covers the last k+1 columns.
// ----------------------------------------------------------------------------
module mpf_win_cell
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             shift,
    input  logic             clear,
    input  mpf_pkg::sample_t col_max,
    input  mpf_pkg::sample_t p_in,
    output mpf_pkg::sample_t p_out
);
    import mpf_pkg::*;

    sample_t p_reg;

    // span maximum, restarted on a register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= MOST_NEG;
        end
        else if (clear)
        begin
            p_reg <= MOST_NEG;
        end
        else if (advance && shift)
        begin
            p_reg <= sample_max(col_max, p_in);
        end
    end

    assign p_out = p_reg;

endmodule

### design/max_pool_2d_forward_top.sv
// Throughput: one sample per cycle while the skid stage is empty, set by the
// chain of seven line-store cells, each doing one read and one write of its
// row memory per cycle.
// Reset: registers return to their defaults, positions to zero and window
// maxima to the most negative value; row memories are not cleared.
// ----------------------------------------------------------------------------
// max_pool_2d_forward_top: streaming 2D max pooling
// Raster samples run through a chain of line cells that builds each column
// maximum, then a chain of window cells that builds the window maximum.
// An output register with a skid stage decouples the two handshakes.
// ----------------------------------------------------------------------------
module max_pool_2d_forward_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mpf_pkg::sample_t                  sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mpf_pkg::sample_t                  pooled,
    output logic                              image_last,
    input  logic                              cfg_we,
    input  logic [mpf_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [mpf_pkg::DIM_W-1:0]         cfg_data
);
    import mpf_pkg::*;

    // configuration, held already bounded
    logic [DIM_W-1:0] chans_reg;
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    logic [KER_W-1:0] kr8_reg;
    logic [KER_W-1:0] kc8_reg;
    logic [KER_W-1:0] st_reg;
    logic [KER_W-1:0] kr;
    logic [KER_W-1:0] kc;
    logic             cfg_restart;

    // raster position and stride phases
    logic [POS_W-1:0] row_pos_reg, row_pos_next;
    logic [POS_W-1:0] col_pos_reg, col_pos_next;
    logic [POS_W-1:0] plane_pos_reg, plane_pos_next;
    logic [KER_W-1:0] row_ph_reg, row_ph_next;
    logic [KER_W-1:0] col_ph_reg, col_ph_next;

    logic             advance;
    logic             in_accept;
    logic             emit;
    logic             last;
    logic [MAX_KERNEL-1:0] row_en;

    // line chain links: index k feeds cell k
    mpf_tag_t tag_c [0:LINE_CELLS];
    sample_t  d_c   [0:LINE_CELLS];
    sample_t  pm_c  [0:LINE_CELLS];

    // window chain
    sample_t  col_max;
    sample_t  p_c   [0:MAX_KERNEL-1];
    logic     w_valid_reg;
    logic     w_emit_reg;
    logic     w_last_reg;
    logic     res_valid;
    sample_t  res_pooled;

    // output register and skid
    logic     out_valid_reg;
    sample_t  pooled_reg;
    logic     image_last_reg;
    logic     skid_valid_reg;
    sample_t  skid_pooled_reg;
    logic     skid_last_reg;

    function automatic logic [DIM_W-1:0] bound_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        if (v == '0)
            return DIM_W'(1);
        else if (v > hi)
            return hi;
        else
            return v;
    endfunction

    function automatic logic [KER_W-1:0] bound_ker(input logic [KER_W-1:0] v,
                                                   input logic [KER_W-1:0] hi);
        if (v == '0)
            return KER_W'(1);
        else if (v > hi)
            return hi;
        else
            return v;
    endfunction

    function automatic logic [KER_W-1:0] phase_step(input logic [KER_W-1:0] ph,
                                                    input logic [KER_W-1:0] st);
        return (KER_W'(ph + KER_W'(1)) == st) ? '0 : KER_W'(ph + KER_W'(1));
    endfunction

    // kernel never taller or wider than the plane
    always_comb
    begin
        kr = (rows_reg < DIM_W'(kr8_reg)) ? rows_reg[KER_W-1:0] : kr8_reg;
        kc = (cols_reg < DIM_W'(kc8_reg)) ? cols_reg[KER_W-1:0] : kc8_reg;
        for (int k = 0; k < MAX_KERNEL; k++)
        begin
            row_en[k] = (KER_W'(k) < kr);
        end
    end

    assign cfg_restart = cfg_we && (cfg_index inside {[REG_CHANNELS:REG_STRIDE]});

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chans_reg <= DIM_W'(1);
            rows_reg  <= DIM_W'(8);
            cols_reg  <= DIM_W'(8);
            kr8_reg   <= KER_W'(2);
            kc8_reg   <= KER_W'(2);
            st_reg    <= KER_W'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CHANNELS:    chans_reg <= bound_dim(cfg_data, DIM_LIMIT);
                REG_IN_ROWS:     rows_reg  <= bound_dim(cfg_data, DIM_LIMIT);
                REG_IN_COLS:     cols_reg  <= bound_dim(cfg_data, COL_LIMIT);
                REG_KERNEL_ROWS: kr8_reg   <= bound_ker(cfg_data[KER_W-1:0], KER_LIMIT);
                REG_KERNEL_COLS: kc8_reg   <= bound_ker(cfg_data[KER_W-1:0], KER_LIMIT);
                REG_STRIDE:      st_reg    <= bound_ker(cfg_data[KER_W-1:0], 4'd15);
                default:         ;
            endcase
        end
    end

    assign advance   = !skid_valid_reg;
    assign in_ready  = advance;
    assign in_accept = in_valid && in_ready;

    // window closing and end-of-image tests for the current sample
    always_comb
    begin
        emit = ((DIM_W'(row_pos_reg) + DIM_W'(1)) >= DIM_W'(kr))
            && ((DIM_W'(col_pos_reg) + DIM_W'(1)) >= DIM_W'(kc))
            && (row_ph_reg == '0) && (col_ph_reg == '0);
        last = ((DIM_W'(plane_pos_reg) + DIM_W'(1)) == chans_reg)
            && ((DIM_W'(row_pos_reg) + DIM_W'(st_reg)) >= rows_reg)
            && ((DIM_W'(col_pos_reg) + DIM_W'(st_reg)) >= cols_reg);
    end

    // raster stepping, phases count from the first full window mod stride
    always_comb
    begin
        col_pos_next   = col_pos_reg;
        row_pos_next   = row_pos_reg;
        plane_pos_next = plane_pos_reg;
        col_ph_next    = col_ph_reg;
        row_ph_next    = row_ph_reg;
        if ((DIM_W'(col_pos_reg) + DIM_W'(1)) >= cols_reg)
        begin
            col_pos_next = '0;
            col_ph_next  = '0;
            if ((DIM_W'(row_pos_reg) + DIM_W'(1)) >= rows_reg)
            begin
                row_pos_next = '0;
                row_ph_next  = '0;
                if ((DIM_W'(plane_pos_reg) + DIM_W'(1)) >= chans_reg)
                    plane_pos_next = '0;
                else
                    plane_pos_next = POS_W'(plane_pos_reg + POS_W'(1));
            end
            else
            begin
                row_pos_next = POS_W'(row_pos_reg + POS_W'(1));
                if ((DIM_W'(row_pos_reg) + DIM_W'(2)) <= DIM_W'(kr))
                    row_ph_next = '0;
                else
                    row_ph_next = phase_step(row_ph_reg, st_reg);
            end
        end
        else
        begin
            col_pos_next = POS_W'(col_pos_reg + POS_W'(1));
            if ((DIM_W'(col_pos_reg) + DIM_W'(2)) <= DIM_W'(kc))
                col_ph_next = '0;
            else
                col_ph_next = phase_step(col_ph_reg, st_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            plane_pos_reg <= '0;
            row_ph_reg    <= '0;
            col_ph_reg    <= '0;
        end
        else if (cfg_restart)
        begin
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            plane_pos_reg <= '0;
            row_ph_reg    <= '0;
            col_ph_reg    <= '0;
        end
        else if (in_accept)
        begin
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            plane_pos_reg <= plane_pos_next;
            row_ph_reg    <= row_ph_next;
            col_ph_reg    <= col_ph_next;
        end
    end

    // head of the line chain
    always_comb
    begin
        tag_c[0].valid = in_accept;
        tag_c[0].col   = COL_W'(col_pos_reg);
        tag_c[0].emit  = emit;
        tag_c[0].last  = last;
        d_c[0]         = sample;
        pm_c[0]        = MOST_NEG;
    end

    // line cells: cell k holds the row k+1 above the incoming one
    for (genvar g = 0; g < LINE_CELLS; g++)
    begin : g_line
        mpf_line_cell u_line
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .row_en  (row_en[g]),
            .tag_in  (tag_c[g]),
            .d_in    (d_c[g]),
            .pm_in   (pm_c[g]),
            .tag_out (tag_c[g+1]),
            .d_out   (d_c[g+1]),
            .pm_out  (pm_c[g+1])
        );
    end

    // oldest row joins the column maximum here
    assign col_max = row_en[MAX_KERNEL-1] ? sample_max(pm_c[LINE_CELLS], d_c[LINE_CELLS])
                                          : pm_c[LINE_CELLS];

    // window cells
    for (genvar g = 0; g < MAX_KERNEL; g++)
    begin : g_win
        mpf_win_cell u_win
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .shift   (tag_c[LINE_CELLS].valid),
            .clear   (cfg_restart),
            .col_max (col_max),
            .p_in    ((g == 0) ? MOST_NEG : p_c[(g == 0) ? 0 : g-1]),
            .p_out   (p_c[g])
        );
    end

    // tag alongside the window cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
            w_emit_reg  <= 1'b0;
            w_last_reg  <= 1'b0;
        end
        else if (advance)
        begin
            w_valid_reg <= tag_c[LINE_CELLS].valid;
            w_emit_reg  <= tag_c[LINE_CELLS].emit;
            w_last_reg  <= tag_c[LINE_CELLS].last;
        end
    end

    // window width picks the cell with the matching span
    assign res_valid  = advance && w_valid_reg && w_emit_reg;
    assign res_pooled = p_c[SEL_W'(kc - KER_W'(1))];

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_ready)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                pooled_reg     <= skid_pooled_reg;
                image_last_reg <= skid_last_reg;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_ready)
            begin
                pooled_reg     <= res_pooled;
                image_last_reg <= w_last_reg;
            end
            else
            begin
                skid_pooled_reg <= res_pooled;
                skid_last_reg   <= w_last_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign pooled     = pooled_reg;
    assign image_last = image_last_reg;

`ifndef SYNTHESIS
    // a parked item always has one ahead of it in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output register is empty");

    // a parked item is not lost while the consumer stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_ready) |=> (skid_valid_reg && $stable(skid_pooled_reg)))
        else $error("skid item dropped or changed under stall");

    // a register write restarts the raster
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_restart |=> (row_pos_reg == '0 && col_pos_reg == '0 && plane_pos_reg == '0))
        else $error("raster position not restarted after register write");

    // stride phases stay below the stride
    assert property (@(posedge clk) disable iff (!rst_n)
        (row_ph_reg < st_reg) && (col_ph_reg < st_reg))
        else $error("stride phase out of range");
`endif

endmodule
